/* sv/eeb_pkg.sv */
// ---------------------------------------------------------------------------
// eeb_pkg
// Types and constants shared by the serial EEPROM byte master.
// ---------------------------------------------------------------------------
package eeb_pkg;

   // Bus segment that the bit sequencer is holding.
   typedef enum logic [3:0] {
      PH_IDLE, PH_RS, PH_SA, PH_SB, PH_TXL, PH_TXH, PH_AKL, PH_AKH,
      PH_RXL, PH_RXH, PH_NKL, PH_NKH, PH_PL, PH_PH, PH_PE
   } phase_type;

   // Which byte of the transfer is on the bus.
   typedef enum logic [2:0] {
      ST_CTRL, ST_ADDR, ST_DATA, ST_RDCTRL, ST_RECV
   } stage_type;

   // Operation codes of a request.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Configuration register indexes (word addressed).
   localparam logic REG_DEVICE_ADDRESS    = 1'b0;
   localparam logic REG_HALF_PERIOD_TICKS = 1'b1;

   localparam int  CSR_ADDR_W           = 3;
   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
   localparam logic [7:0] HALF_PERIOD_RESET    = 8'd2;
   localparam logic [3:0] BITS_PER_BYTE        = 4'd8;

   // Line levels held between transfers.
   typedef struct packed {
      logic scl;
      logic sda;
      logic drv;
   } lines_type;

   // One request: one tick of the bus sequencer.
   typedef struct packed {
      logic       start_request;
      logic       operation;
      logic [7:0] memory_address;
      logic [7:0] write_data;
      logic       sampled_sda;
   } req_type;

   // One response: line levels and status for one tick.
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive_enable;
      logic       busy_res;
      logic       done_res;
      logic       nak_error;
      logic [7:0] rd_byte;
   } rsp_type;

endpackage

/* sv/eeb_req_if.sv */
// ---------------------------------------------------------------------------
// eeb_req_if
// Request channel: one bus tick with an optional transfer start.
// ---------------------------------------------------------------------------
interface eeb_req_if;
   logic       valid;
   logic       ready;
   logic       start_request;
   logic       operation;
   logic [7:0] memory_address;
   logic [7:0] write_data;
   logic       sampled_sda;

   modport source (
      output valid, start_request, operation, memory_address, write_data, sampled_sda,
      input  ready
   );
   modport sink (
      input  valid, start_request, operation, memory_address, write_data, sampled_sda,
      output ready
   );
endinterface

/* sv/eeb_rsp_if.sv */
// ---------------------------------------------------------------------------
// eeb_rsp_if
// Response channel: line levels and transfer status for one bus tick.
// ---------------------------------------------------------------------------
interface eeb_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_drive_enable;
   logic       busy_res;
   logic       done_res;
   logic       nak_error;
   logic [7:0] rd_byte;

   modport source (
      output valid, scl_level, sda_level, sda_drive_enable, busy_res, done_res,
             nak_error, rd_byte,
      input  ready
   );
   modport sink (
      input  valid, scl_level, sda_level, sda_drive_enable, busy_res, done_res,
             nak_error, rd_byte,
      output ready
   );
endinterface

/* sv/i2c_eeprom_byte_master.sv */
// ---------------------------------------------------------------------------
// i2c_eeprom_byte_master
// I2C master for a serial EEPROM: byte write and random read, one tick per
// request.
// ---------------------------------------------------------------------------
// Usage:
//   Every request on req_bus is one tick of the bus sequencer. A request with
//   start_request set while the sequencer is idle latches operation, address
//   and data and starts a transfer; later start requests are ignored until it
//   ends. sampled_sda is the SDA level seen during that tick.
//   Every request gives exactly one response on rsp_bus: the SCL, SDA and SDA
//   drive levels for that tick, plus busy, done, NAK error and read data.
//   The csr_ APB port sets the device address (offset 0) and the half period
//   in ticks (offset 4); write it only while no transfer is running.
// Timing:
//   A request is captured in an input register and is processed into the
//   response register when the response slot is free, so a stalled rsp_bus
//   can hold it back in the input register.
//   The sequencer step is a single pass of logic, so one request is taken
//   every cycle while responses drain.
//   When rsp_bus stalls, the response register holds, the input register
//   fills, and req_bus.ready drops until the response is taken.
// Reset:
//   Synchronous, active high. Registers return to their defaults, the
//   sequencer goes idle with SCL and SDA high and driven, and both pipeline
//   registers are emptied.
// ---------------------------------------------------------------------------
module i2c_eeprom_byte_master
   import eeb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   eeb_req_if.sink               req_bus,
   eeb_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Configuration registers.
   logic [6:0] dev_addr_ff;
   logic [7:0] half_ticks_ff;

   // Pipeline registers.
   logic      in_valid_ff;
   req_type   in_req_ff;
   logic      out_valid_ff;
   rsp_type   out_rsp_ff;
   rsp_type   out_rsp_in;

   // Sequencer state.
   phase_type  phase_ff,   phase_in;
   stage_type  stage_ff,   stage_in;
   logic [3:0] bit_cnt_ff, bit_cnt_in;
   logic [7:0] shift_ff,   shift_in;
   logic [7:0] delay_ff,   delay_in;
   logic       op_ff,      op_in;
   logic [7:0] addr_ff,    addr_in;
   logic [7:0] data_ff,    data_in;
   lines_type  lines_ff,   lines_in;

   logic advance;
   logic csr_write;

   // The step runs when an input is held and the response slot is free.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // APB register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         REG_DEVICE_ADDRESS:    csr_prdata = {25'd0, dev_addr_ff};
         REG_HALF_PERIOD_TICKS: csr_prdata = {24'd0, half_ticks_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff   <= DEVICE_ADDRESS_RESET;
         half_ticks_ff <= HALF_PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_DEVICE_ADDRESS:    dev_addr_ff   <= csr_pwdata[6:0];
            REG_HALF_PERIOD_TICKS: half_ticks_ff <= csr_pwdata[7:0];
            default:               dev_addr_ff   <= dev_addr_ff;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_req_ff.start_request  <= req_bus.start_request;
         in_req_ff.operation      <= req_bus.operation;
         in_req_ff.memory_address <= req_bus.memory_address;
         in_req_ff.write_data     <= req_bus.write_data;
         in_req_ff.sampled_sda    <= req_bus.sampled_sda;
      end
   end

   // One tick of the sequencer: line levels, then segment timing and moves.
   always_comb begin
      logic [7:0] half;
      logic [3:0] bit_next;
      logic [2:0] levels;
      half     = (half_ticks_ff == 8'd0) ? 8'd1 : half_ticks_ff;
      bit_next = 4'd0;
      levels   = 3'b111;

      phase_in   = phase_ff;
      stage_in   = stage_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      delay_in   = delay_ff;
      op_in      = op_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      lines_in   = lines_ff;
      out_rsp_in = '0;

      // A start request in idle latches the transfer and enters the start.
      if (phase_in == PH_IDLE && in_req_ff.start_request) begin
         op_in      = in_req_ff.operation;
         addr_in    = in_req_ff.memory_address;
         data_in    = in_req_ff.write_data;
         stage_in   = ST_CTRL;
         bit_cnt_in = 4'd0;
         shift_in   = 8'd0;
         phase_in   = PH_SA;
         delay_in   = half;
      end

      if (phase_in == PH_IDLE) begin
         out_rsp_in.scl_level        = lines_ff.scl;
         out_rsp_in.sda_level        = lines_ff.sda;
         out_rsp_in.sda_drive_enable = lines_ff.drv;
      end else begin
         out_rsp_in.busy_res = 1'b1;
         // Levels are SCL, SDA and SDA drive, in that order.
         unique case (phase_in)
            PH_RS:  levels = 3'b011;
            PH_SB:  levels = 3'b101;
            PH_TXL: levels = {1'b0, shift_in[7], 1'b1};
            PH_TXH: levels = {1'b1, shift_in[7], 1'b1};
            PH_AKL, PH_RXL: levels = 3'b010;
            PH_AKH, PH_RXH: levels = 3'b110;
            PH_NKL: levels = 3'b011;
            PH_PL:  levels = 3'b001;
            PH_PH:  levels = 3'b101;
            default: levels = 3'b111;
         endcase
         out_rsp_in.scl_level        = levels[2];
         out_rsp_in.sda_level        = levels[1];
         out_rsp_in.sda_drive_enable = levels[0];

         if (delay_in > 8'd1) begin
            delay_in = delay_in - 8'd1;
         end else begin
            delay_in = half;
            unique case (phase_in)
               PH_RS: phase_in = PH_SA;
               PH_SA: phase_in = PH_SB;
               PH_SB: begin
                  shift_in   = {dev_addr_ff, (stage_in == ST_RDCTRL) ? OP_READ : OP_WRITE};
                  bit_cnt_in = 4'd0;
                  phase_in   = PH_TXL;
               end
               PH_TXL: phase_in = PH_TXH;
               PH_TXH: begin
                  bit_next   = bit_cnt_in + 4'd1;
                  shift_in   = {shift_in[6:0], 1'b0};
                  bit_cnt_in = bit_next;
                  phase_in   = (bit_next >= BITS_PER_BYTE) ? PH_AKL : PH_TXL;
               end
               PH_AKL: phase_in = PH_AKH;
               PH_AKH: begin
                  // A high acknowledge aborts without a stop.
                  if (in_req_ff.sampled_sda) begin
                     out_rsp_in.done_res  = 1'b1;
                     out_rsp_in.nak_error = 1'b1;
                     phase_in = PH_IDLE;
                     delay_in = 8'd0;
                     lines_in = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
                  end else begin
                     unique case (stage_in)
                        ST_CTRL: begin
                           stage_in   = ST_ADDR;
                           shift_in   = addr_in;
                           bit_cnt_in = 4'd0;
                           phase_in   = PH_TXL;
                        end
                        ST_ADDR: begin
                           if (op_in == OP_READ) begin
                              stage_in = ST_RDCTRL;
                              phase_in = PH_RS;
                           end else begin
                              stage_in   = ST_DATA;
                              shift_in   = data_in;
                              bit_cnt_in = 4'd0;
                              phase_in   = PH_TXL;
                           end
                        end
                        ST_DATA: phase_in = PH_PL;
                        default: begin
                           stage_in   = ST_RECV;
                           shift_in   = 8'd0;
                           bit_cnt_in = 4'd0;
                           phase_in   = PH_RXL;
                        end
                     endcase
                  end
               end
               PH_RXL: phase_in = PH_RXH;
               PH_RXH: begin
                  bit_next   = bit_cnt_in + 4'd1;
                  shift_in   = {shift_in[6:0], in_req_ff.sampled_sda};
                  bit_cnt_in = bit_next;
                  phase_in   = (bit_next >= BITS_PER_BYTE) ? PH_NKL : PH_RXL;
               end
               PH_NKL: phase_in = PH_NKH;
               PH_NKH: phase_in = PH_PL;
               PH_PL:  phase_in = PH_PH;
               PH_PH:  phase_in = PH_PE;
               default: begin
                  // End of stop: report and return to idle with lines high.
                  out_rsp_in.done_res = 1'b1;
                  out_rsp_in.rd_byte  = (op_in == OP_READ) ? shift_in : 8'd0;
                  phase_in = PH_IDLE;
                  delay_in = 8'd0;
                  lines_in = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
               end
            endcase
         end
      end
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         stage_ff   <= ST_CTRL;
         bit_cnt_ff <= 4'd0;
         shift_ff   <= 8'd0;
         delay_ff   <= 8'd0;
         op_ff      <= OP_WRITE;
         addr_ff    <= 8'd0;
         data_ff    <= 8'd0;
         lines_ff   <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      end else if (advance) begin
         phase_ff   <= phase_in;
         stage_ff   <= stage_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         delay_ff   <= delay_in;
         op_ff      <= op_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
         lines_ff   <= lines_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.scl_level        = out_rsp_ff.scl_level;
   assign rsp_bus.sda_level        = out_rsp_ff.sda_level;
   assign rsp_bus.sda_drive_enable = out_rsp_ff.sda_drive_enable;
   assign rsp_bus.busy_res         = out_rsp_ff.busy_res;
   assign rsp_bus.done_res         = out_rsp_ff.done_res;
   assign rsp_bus.nak_error        = out_rsp_ff.nak_error;
   assign rsp_bus.rd_byte          = out_rsp_ff.rd_byte;

   // A finished transfer leaves the sequencer idle until the next tick runs.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rsp_ff.done_res |-> phase_ff == PH_IDLE)
      else $error("sequencer not idle after done");

   // Done, NAK and a released SDA only occur inside a transfer.
   a_status_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_rsp_ff.done_res || !out_rsp_ff.sda_drive_enable)
      |-> out_rsp_ff.busy_res)
      else $error("transfer status outside busy");

   // Read data is only reported on a successful finish.
   a_rdata_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rsp_ff.rd_byte != 8'd0
      |-> out_rsp_ff.done_res && !out_rsp_ff.nak_error)
      else $error("read data without successful done");

   // A stalled response stays in place and the step does not run over it.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |=> out_valid_ff && $stable(out_rsp_ff))
      else $error("response changed while stalled");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Tick-level testbench for the serial EEPROM byte master.
// Every request is one sequencer tick, and every response is checked against
// a cycle model of the bus sequencer that runs in the testbench. A table of
// directed transfers comes first: writes, reads, NAK aborts at each
// acknowledge, and odd register settings. Random transfers follow under
// two more register settings. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
   import eeb_pkg::*;

   // One transfer as the stimulus sees it.
   typedef struct packed {
      logic [6:0] dev;
      logic [7:0] half;
      logic       op;
      logic [7:0] maddr;
      logic [7:0] wdata;
      logic [7:0] rx;
      logic       nak_on;
      stage_type  nak_stg;
      logic       busy_starts;
      logic       noisy;
      logic [3:0] lead;
      logic       typed;
      logic       t_nak;
      logic [7:0] t_rd;
   } xfer_t;

   localparam int ROWS       = 14;
   localparam int PHASES     = 2;
   localparam int MAX_REPORT = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   eeb_req_if req_bus ();
   eeb_rsp_if rsp_bus ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   i2c_eeprom_byte_master u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock: 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sequencer model state and its copy of the registers.
   phase_type  ph;
   stage_type  stg;
   logic [3:0] nbits;
   logic [7:0] shreg;
   logic [7:0] dly;
   logic       op_q;
   logic [7:0] addr_q;
   logic [7:0] data_q;
   lines_type  idle_lines;
   logic [6:0] dev_addr;
   logic [7:0] half_cfg;

   rsp_type predicted_ticks [$];
   xfer_t   dir_rows [ROWS];

   bit calm_send;
   bit calm_take;
   int mismatches;
   int n_ticks;
   int n_done;
   int n_naks;
   int n_reads;
   int n_cfg;

   function automatic void enter_phase(input phase_type p);
      ph  = p;
      dly = (half_cfg == 8'd0) ? 8'd1 : half_cfg;
   endfunction

   function automatic void load_byte(input logic [7:0] b);
      shreg = b;
      nbits = 4'd0;
      enter_phase(PH_TXL);
   endfunction

   // Advance the sequencer model by one tick and return the line levels and
   // status that the block should show for it.
   function automatic rsp_type step_sequencer(input req_type r);
      rsp_type o;
      o = '0;
      if (ph == PH_IDLE && r.start_request) begin
         op_q   = r.operation;
         addr_q = r.memory_address;
         data_q = r.write_data;
         stg    = ST_CTRL;
         nbits  = 4'd0;
         shreg  = 8'd0;
         enter_phase(PH_SA);
      end

      if (ph == PH_IDLE) begin
         {o.scl_level, o.sda_level, o.sda_drive_enable} = idle_lines;
      end else begin
         o.busy_res = 1'b1;
         // Levels of the segment being held.
         case (ph)
            PH_RS:          {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b011;
            PH_SA:          {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b111;
            PH_SB:          {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b101;
            PH_TXL:         {o.scl_level, o.sda_level, o.sda_drive_enable} = {1'b0, shreg[7], 1'b1};
            PH_TXH:         {o.scl_level, o.sda_level, o.sda_drive_enable} = {1'b1, shreg[7], 1'b1};
            PH_AKL, PH_RXL: {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b010;
            PH_AKH, PH_RXH: {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b110;
            PH_NKL:         {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b011;
            PH_NKH:         {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b111;
            PH_PL:          {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b001;
            PH_PH:          {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b101;
            default:        {o.scl_level, o.sda_level, o.sda_drive_enable} = 3'b111;
         endcase

         // Move on once the segment has been held for the half period.
         if (dly > 8'd1) begin
            dly = dly - 8'd1;
         end else begin
            case (ph)
               PH_RS: enter_phase(PH_SA);
               PH_SA: enter_phase(PH_SB);
               PH_SB: load_byte({dev_addr, (stg == ST_RDCTRL) ? OP_READ : OP_WRITE});
               PH_TXL: enter_phase(PH_TXH);
               PH_TXH: begin
                  shreg = {shreg[6:0], 1'b0};
                  nbits = nbits + 4'd1;
                  enter_phase(nbits >= BITS_PER_BYTE ? PH_AKL : PH_TXL);
               end
               PH_AKL: enter_phase(PH_AKH);
               PH_AKH: begin
                  if (r.sampled_sda) begin
                     // Missing acknowledge: abort with SCL left low.
                     o.done_res  = 1'b1;
                     o.nak_error = 1'b1;
                     ph          = PH_IDLE;
                     dly         = 8'd0;
                     idle_lines  = 3'b011;
                  end else begin
                     case (stg)
                        ST_CTRL: begin
                           stg = ST_ADDR;
                           load_byte(addr_q);
                        end
                        ST_ADDR: begin
                           if (op_q == OP_READ) begin
                              stg = ST_RDCTRL;
                              enter_phase(PH_RS);
                           end else begin
                              stg = ST_DATA;
                              load_byte(data_q);
                           end
                        end
                        ST_DATA: enter_phase(PH_PL);
                        default: begin
                           stg   = ST_RECV;
                           shreg = 8'd0;
                           nbits = 4'd0;
                           enter_phase(PH_RXL);
                        end
                     endcase
                  end
               end
               PH_RXL: enter_phase(PH_RXH);
               PH_RXH: begin
                  shreg = {shreg[6:0], r.sampled_sda};
                  nbits = nbits + 4'd1;
                  enter_phase(nbits >= BITS_PER_BYTE ? PH_NKL : PH_RXL);
               end
               PH_NKL: enter_phase(PH_NKH);
               PH_NKH: enter_phase(PH_PL);
               PH_PL:  enter_phase(PH_PH);
               PH_PH:  enter_phase(PH_PE);
               default: begin
                  o.done_res = 1'b1;
                  if (op_q == OP_READ) begin
                     o.rd_byte = shreg;
                  end
                  ph         = PH_IDLE;
                  dly        = 8'd0;
                  idle_lines = 3'b111;
               end
            endcase
         end
      end
      return o;
   endfunction

   function automatic req_type rand_req();
      req_type r;
      r.start_request  = $urandom_range(0, 1);
      r.operation      = $urandom_range(0, 1);
      r.memory_address = $urandom_range(0, 255);
      r.write_data     = $urandom_range(0, 255);
      r.sampled_sda    = $urandom_range(0, 1);
      return r;
   endfunction

   function automatic void cmp_field(input string f, input int unsigned want,
                                     input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORT) begin
            $error("%s: expected %0h, got %0h", f, want, got);
         end
      end
   endfunction

   // Send one request after a random gap, then predict its response.
   task automatic send_tick(input req_type r, input logic typed, input logic t_nak,
                            input logic [7:0] t_rd);
      int      gap;
      rsp_type want;
      gap = calm_send ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.start_request  <= r.start_request;
      req_bus.operation      <= r.operation;
      req_bus.memory_address <= r.memory_address;
      req_bus.write_data     <= r.write_data;
      req_bus.sampled_sda    <= r.sampled_sda;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);

      want = step_sequencer(r);
      // Directed rows carry their final status typed in.
      if (typed && want.done_res) begin
         want.nak_error = t_nak;
         want.rd_byte   = t_rd;
      end
      predicted_ticks.push_back(want);
      n_ticks++;
      if (want.done_res) begin
         n_done++;
         if (want.nak_error) n_naks++;
         else if (op_q == OP_READ) n_reads++;
      end
   endtask

   // One whole transfer: idle lead-in, start tick, then ticks until the
   // sequencer is idle again. SDA answers acknowledges and feeds the
   // received byte unless the transfer is a noisy one.
   task automatic run_transfer(input xfer_t x);
      req_type r;
      int      i;
      for (i = 0; i < x.lead; i++) begin
         r = rand_req();
         r.start_request = 1'b0;
         send_tick(r, 1'b0, 1'b0, 8'd0);
      end
      r = rand_req();
      r.start_request  = 1'b1;
      r.operation      = x.op;
      r.memory_address = x.maddr;
      r.write_data     = x.wdata;
      send_tick(r, x.typed, x.t_nak, x.t_rd);
      while (ph != PH_IDLE) begin
         r = rand_req();
         if (x.busy_starts) r.start_request = 1'b1;
         if (!x.noisy) begin
            if (ph == PH_AKH) r.sampled_sda = x.nak_on && (stg == x.nak_stg);
            else if (ph == PH_RXH) r.sampled_sda = x.rx[3'd7 - nbits[2:0]];
         end
         send_tick(r, x.typed, x.t_nak, x.t_rd);
      end
   endtask

   // Stop sending and let every predicted response drain.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (predicted_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({reg_idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (reg_idx == REG_DEVICE_ADDRESS) dev_addr = value[6:0];
      else half_cfg = value[7:0];
      n_cfg++;
   endtask

   // Write both registers; the upper bits are junk that the block must drop.
   task automatic set_config(input logic [6:0] dev, input logic [7:0] half);
      logic [31:0] v;
      v = $urandom;
      v[6:0] = dev;
      csr_write(REG_DEVICE_ADDRESS, v);
      v = $urandom;
      v[7:0] = half;
      csr_write(REG_HALF_PERIOD_TICKS, v);
   endtask

   // Response side: random stall per response, then compare with the oldest
   // prediction.
   initial begin
      int      stall;
      rsp_type got;
      rsp_type want;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = calm_take ? 0 : $urandom_range(0, 18);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (rsp_bus.valid !== 1'b1) @(posedge clock);
         got.scl_level        = rsp_bus.scl_level;
         got.sda_level        = rsp_bus.sda_level;
         got.sda_drive_enable = rsp_bus.sda_drive_enable;
         got.busy_res         = rsp_bus.busy_res;
         got.done_res         = rsp_bus.done_res;
         got.nak_error        = rsp_bus.nak_error;
         got.rd_byte          = rsp_bus.rd_byte;
         if (predicted_ticks.size() == 0) begin
            mismatches++;
            $error("response arrived with no request waiting for it");
         end else begin
            want = predicted_ticks.pop_front();
            cmp_field("scl_level", want.scl_level, got.scl_level);
            cmp_field("sda_level", want.sda_level, got.sda_level);
            cmp_field("sda_drive_enable", want.sda_drive_enable, got.sda_drive_enable);
            cmp_field("busy_res", want.busy_res, got.busy_res);
            cmp_field("done_res", want.done_res, got.done_res);
            cmp_field("nak_error", want.nak_error, got.nak_error);
            cmp_field("rd_byte", want.rd_byte, got.rd_byte);
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #(64'd10_000_000);
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus: directed transfers, then random phases.
   initial begin
      int    i;
      int    p;
      int    t0;
      int    waited;
      xfer_t x;
      int    ph_dev  [PHASES];
      int    ph_half [PHASES];
      int    ph_ticks[PHASES];
      bit    ph_calm [PHASES];

      ph_dev   = '{-1, 127};
      ph_half  = '{1, 3};
      ph_ticks = '{110, 1};
      ph_calm  = '{1'b0, 1'b0};

      req_bus.valid          = 1'b0;
      req_bus.start_request  = 1'b0;
      req_bus.operation      = OP_WRITE;
      req_bus.memory_address = 8'd0;
      req_bus.write_data     = 8'd0;
      req_bus.sampled_sda    = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = 32'd0;

      // Model reset state.
      ph         = PH_IDLE;
      stg        = ST_CTRL;
      nbits      = 4'd0;
      shreg      = 8'd0;
      dly        = 8'd0;
      op_q       = OP_WRITE;
      addr_q     = 8'd0;
      data_q     = 8'd0;
      idle_lines = 3'b111;
      dev_addr   = DEVICE_ADDRESS_RESET;
      half_cfg   = HALF_PERIOD_RESET;

      // dev, half, op, addr, data, rx byte, nak, nak at, starts while busy,
      // noisy, idle lead, typed, typed nak, typed read data
      dir_rows[0]  = '{7'd80,  8'd2, OP_WRITE, 8'h00, 8'h00, 8'h00, 1'b0, ST_CTRL,
                       1'b0, 1'b0, 4'd1, 1'b1, 1'b0, 8'h00};
      dir_rows[1]  = '{7'd80,  8'd1, OP_WRITE, 8'hff, 8'hff, 8'h00, 1'b0, ST_CTRL,
                       1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 8'h00};
      dir_rows[2]  = '{7'd80,  8'd1, OP_READ,  8'h00, 8'h00, 8'hff, 1'b0, ST_CTRL,
                       1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 8'hff};
      dir_rows[3]  = '{7'd80,  8'd1, OP_READ,  8'hff, 8'hff, 8'h00, 1'b0, ST_CTRL,
                       1'b0, 1'b0, 4'd2, 1'b1, 1'b0, 8'h00};
      dir_rows[4]  = '{7'd80,  8'd1, OP_READ,  8'h5a, 8'hc3, 8'ha5, 1'b0, ST_CTRL,
                       1'b1, 1'b0, 4'd0, 1'b1, 1'b0, 8'ha5};
      dir_rows[5]  = '{7'd80,  8'd1, OP_WRITE, 8'h12, 8'h34, 8'h00, 1'b1, ST_CTRL,
                       1'b0, 1'b0, 4'd0, 1'b1, 1'b1, 8'h00};
      dir_rows[6]  = '{7'd80,  8'd1, OP_WRITE, 8'h56, 8'h78, 8'h00, 1'b1, ST_ADDR,
                       1'b0, 1'b0, 4'd1, 1'b1, 1'b1, 8'h00};
      dir_rows[7]  = '{7'd80,  8'd1, OP_WRITE, 8'h9a, 8'hbc, 8'h00, 1'b1, ST_DATA,
                       1'b0, 1'b0, 4'd0, 1'b1, 1'b1, 8'h00};
      dir_rows[8]  = '{7'd80,  8'd1, OP_READ,  8'hde, 8'hf0, 8'hff, 1'b1, ST_ADDR,
                       1'b0, 1'b0, 4'd2, 1'b1, 1'b1, 8'h00};
      dir_rows[9]  = '{7'd80,  8'd1, OP_READ,  8'h3c, 8'hc3, 8'hff, 1'b1, ST_RDCTRL,
                       1'b1, 1'b0, 4'd0, 1'b1, 1'b1, 8'h00};
      dir_rows[10] = '{7'd80,  8'd1, OP_WRITE, 8'h81, 8'h7e, 8'h00, 1'b0, ST_CTRL,
                       1'b0, 1'b0, 4'd3, 1'b1, 1'b0, 8'h00};
      dir_rows[11] = '{7'd127, 8'd0, OP_READ,  8'h80, 8'h01, 8'h81, 1'b0, ST_CTRL,
                       1'b0, 1'b0, 4'd1, 1'b1, 1'b0, 8'h81};
      dir_rows[12] = '{7'd0,   8'd1, OP_WRITE, 8'h01, 8'h80, 8'h00, 1'b0, ST_CTRL,
                       1'b1, 1'b0, 4'd0, 1'b1, 1'b0, 8'h00};
      dir_rows[13] = '{7'd0,   8'd1, OP_READ,  8'h7f, 8'hfe, 8'h3c, 1'b1, ST_CTRL,
                       1'b0, 1'b0, 4'd1, 1'b1, 1'b1, 8'h00};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed transfers; registers change only between rows.
      for (i = 0; i < ROWS; i++) begin
         if (dir_rows[i].dev != dev_addr || dir_rows[i].half != half_cfg) begin
            quiesce();
            set_config(dir_rows[i].dev, dir_rows[i].half);
         end
         calm_send = ($urandom_range(0, 3) == 0);
         calm_take = ($urandom_range(0, 3) == 0);
         run_transfer(dir_rows[i]);
      end

      // Random transfers under two register settings. The second phase
      // runs a single transfer at a slower half period.
      for (p = 0; p < PHASES; p++) begin
         quiesce();
         set_config((ph_dev[p] < 0) ? 7'($urandom_range(0, 127)) : 7'(ph_dev[p]),
                    (ph_half[p] < 0) ? 8'($urandom_range(1, 4)) : 8'(ph_half[p]));
         t0 = n_ticks;
         while (n_ticks - t0 < ph_ticks[p]) begin
            x.dev         = dev_addr;
            x.half        = half_cfg;
            x.op          = $urandom_range(0, 1);
            x.maddr       = $urandom_range(0, 255);
            x.wdata       = $urandom_range(0, 255);
            x.rx          = $urandom_range(0, 255);
            x.nak_on      = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 2))
               0:       x.nak_stg = ST_CTRL;
               1:       x.nak_stg = ST_ADDR;
               default: x.nak_stg = (x.op == OP_READ) ? ST_RDCTRL : ST_DATA;
            endcase
            x.busy_starts = $urandom_range(0, 1);
            x.noisy       = ($urandom_range(0, 7) == 0);
            x.lead        = $urandom_range(0, 3);
            x.typed       = 1'b0;
            x.t_nak       = 1'b0;
            x.t_rd        = 8'd0;
            calm_send = ph_calm[p] || ($urandom_range(0, 3) == 0);
            calm_take = ph_calm[p] || ($urandom_range(0, 3) == 0);
            run_transfer(x);
         end
      end

      // Drain the last responses, then watch a little longer for extras.
      req_bus.valid <= 1'b0;
      calm_take = 1'b0;
      for (waited = 0; waited < 5000 && predicted_ticks.size() != 0; waited++) begin
         @(posedge clock);
      end
      if (predicted_ticks.size() != 0) begin
         mismatches++;
         $error("%0d predicted responses never arrived", predicted_ticks.size());
      end
      repeat (40) @(posedge clock);

      $display("Ran %0d bus ticks: %0d transfers ended, %0d with a NAK, %0d good reads.",
               n_ticks, n_done, n_naks, n_reads);
      $display("Made %0d register writes; %0d response mismatches.", n_cfg, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
